/* hdl/twcs_pkg.sv */
// Shared types and constants of the textured wall column shader.
package twcs_pkg;

  localparam int TexSizeDef      = 64;
  localparam int ScreenHeightDef = 512;
  localparam int ScreenWidthDef  = 1024;

  localparam logic [1:0] OP_TEXEL = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_PIXEL = 2'd2;

  localparam logic REG_PLAYER_X = 1'b0;
  localparam logic REG_PLAYER_Y = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [13:0]        texel_addr;
    logic [23:0]        texel_color;
    logic               hit_side;
    logic signed [15:0] ray_dir_x;
    logic signed [15:0] ray_dir_y;
    logic [23:0]        perp_distance;
    logic [15:0]        wall_height;
    logic [8:0]         top_row;
    logic [9:0]         stop_row;
    logic [9:0]         column;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  pixel_column;
    logic [8:0]  pixel_row;
    logic [23:0] pixel_color;
    logic        last;
  } out_item_t;

endpackage

/* hdl/twcs_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module twcs_div #(
  parameter int NumW = 36,
  parameter int DenW = 25
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] numer,
  input  logic [DenW-1:0] denom,
  output logic            busy,
  output logic            done,
  output logic [NumW-1:0] quot
);

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num;
  logic [DenW-1:0] den;
  logic [DenW:0]   rem;
  logic [CntW-1:0] cnt;
  logic [DenW:0]   trial;
  logic [DenW:0]   shifted;

  always_comb begin
    shifted = {rem[DenW-1:0], num[NumW-1]};
    trial   = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      num  <= numer;
      den  <= denom;
      rem  <= '0;
      cnt  <= CntW'(NumW);
    end else if (busy) begin
      // shift in one numerator bit, subtract when it fits
      if (!trial[DenW]) begin
        rem <= trial;
        num <= {num[NumW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        num <= {num[NumW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quot = num;

endmodule

/* hdl/twcs_mul.sv */
// Shared registered multiplier: signed 25 x 25 product.
module twcs_mul (
  input  logic               clk,
  input  logic signed [24:0] a,
  input  logic signed [24:0] b,
  output logic signed [49:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* hdl/textured_wall_column_shader_core.sv */
// Top level: texture store, column setup sequencer and pixel shading.
//
// channel | handshake     | payload
// in      | in_valid/stall| in_item  (twcs_pkg::in_item_t)
// out     | out_valid/stall| out_item (twcs_pkg::out_item_t)
// cfg     | cfg_we        | cfg_index, cfg_data
//
// Texel write and ignored requests: finished on acceptance. Pixel: accept, store read,
// three multiply/collect passes, one per channel, emit; emit waits while the
// output register still holds an unclaimed result.
// Column start: runs through the shared divider (36 quotient bits, run for row step
// and again for shade) and two multiplier passes.
// Reset clears all control state; the texture store is not cleared.
// in_stall is high during reset and whenever the sequencer is busy.
module textured_wall_column_shader_core #(
  parameter int TEX_SIZE      = twcs_pkg::TexSizeDef,
  parameter int SCREEN_HEIGHT = twcs_pkg::ScreenHeightDef,
  parameter int SCREEN_WIDTH  = twcs_pkg::ScreenWidthDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  twcs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output twcs_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data
);

  localparam int TW    = $clog2(TEX_SIZE);
  localparam int DEPTH = 4 * TEX_SIZE * TEX_SIZE;
  localparam int AW    = TW * 2 + 2;
  localparam int NUMW  = 36;

  typedef enum logic [3:0] {
    S_IDLE, S_FRAC, S_FRAC2, S_STEP, S_STEPW, S_POS, S_POS2,
    S_SHADE, S_SHADEW, S_RD, S_MUL, S_COL, S_OUT
  } state_t;

  state_t state;

  logic [23:0] player_x, player_y;
  logic [23:0] mem [DEPTH];
  logic [23:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic [1:0]  tex_sel;
  logic [TW-1:0] tex_col;
  logic [47:0] tex_pos;
  logic [23:0] row_step;
  logic [16:0] shade;
  logic [9:0]  cur_row, end_row, cur_col;
  logic        active;
  twcs_pkg::in_item_t req;
  logic [15:0] lh;

  // shared multiplier operands
  logic signed [24:0] ma, mb;
  logic signed [49:0] mp;
  twcs_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  logic div_start, div_busy, div_done;
  logic [NUMW-1:0] dnum, dquot;
  logic [24:0] dden;
  twcs_div #(.NumW(NUMW), .DenW(25)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(dnum), .denom(dden),
    .busy(div_busy), .done(div_done), .quot(dquot)
  );

  logic [1:0] chan;
  logic [23:0] color_acc;
  logic in_acc, out_acc, emit;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = rst || (state != S_IDLE);
  // emit only into a free or draining output register
  assign emit = (state == S_OUT) && (!out_valid || !out_stall);

  logic signed [17:0] offs;
  logic [15:0] frac;
  logic [TW-1:0] tx_raw;
  logic mirror;
  logic [9:0] de_clamp;
  logic [TW-1:0] tex_row;

  always_comb begin
    offs = 18'(signed'({1'b0, req.top_row})) - 18'(SCREEN_HEIGHT / 2)
         + 18'(signed'({1'b0, lh[15:1]}));
    frac = (req.hit_side ? player_x[15:0] : player_y[15:0]) + 16'(mp[49:14]);
    tx_raw = frac[15 -: TW];
    mirror = (!req.hit_side && req.ray_dir_x > 0) || (req.hit_side && req.ray_dir_y < 0);
    de_clamp = ({1'b0, req.stop_row} > 11'(SCREEN_HEIGHT)) ? 10'(SCREEN_HEIGHT)
                                                            : req.stop_row;
    tex_row = tex_pos[16 +: TW];
    dnum = '0;
    dden = '0;
    unique case (state)
      S_STEP:  begin
        dnum = NUMW'(TEX_SIZE) << 16;
        dden = {9'd0, lh};
      end
      default: begin
        dnum = NUMW'(5) << 32;
        dden = 25'(5 << 16) + {1'b0, req.perp_distance};
      end
    endcase
    div_start = (state == S_STEP || state == S_SHADE) && !div_busy && !div_done;
    ma = '0;
    mb = '0;
    unique case (state)
      S_FRAC: begin
        ma = signed'({1'b0, req.perp_distance});
        mb = 25'(req.hit_side ? req.ray_dir_x : req.ray_dir_y);
      end
      S_POS: begin
        ma = 25'(offs);
        mb = signed'({1'b0, row_step});
      end
      default: begin
        ma = signed'({17'd0, rd_data[8*chan +: 8]});
        mb = signed'({8'd0, shade});
      end
    endcase
    rd_addr = {tex_sel, tex_row, tex_col};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x <= '0;
      player_y <= '0;
    end else if (cfg_we) begin
      if (cfg_index == twcs_pkg::REG_PLAYER_X) player_x <= cfg_data;
      else player_y <= cfg_data;
    end
    if (in_acc && in_item.opcode == twcs_pkg::OP_TEXEL)
      mem[in_item.texel_addr[AW-1:0]] <= in_item.texel_color;
    if (state == S_RD) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; active <= 1'b0; out_valid <= 1'b0;
      tex_sel <= '0; tex_col <= '0; tex_pos <= '0; row_step <= '0;
      shade <= '0; cur_row <= '0; end_row <= '0; cur_col <= '0; chan <= '0;
    end else begin
      if (out_acc && !emit) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_acc) begin
          req <= in_item;
          lh  <= (in_item.wall_height == 16'd0) ? 16'd1 : in_item.wall_height;
          if (in_item.opcode == twcs_pkg::OP_START) state <= S_FRAC;
          else if (in_item.opcode == twcs_pkg::OP_PIXEL) begin
            if (active && cur_row < end_row) state <= S_RD;
            else active <= 1'b0;
          end
        end
        S_FRAC:  state <= S_FRAC2;
        S_FRAC2: begin
          tex_col <= mirror ? ~tx_raw : tx_raw;
          tex_sel <= req.hit_side ? ((req.ray_dir_y > 0) ? 2'd2 : 2'd3)
                                  : ((req.ray_dir_x > 0) ? 2'd0 : 2'd1);
          state <= S_STEP;
        end
        S_STEP:  state <= S_STEPW;
        S_STEPW: if (div_done) begin
          row_step <= dquot[23:0];
          state <= S_POS;
        end
        S_POS:   state <= S_POS2;
        S_POS2:  begin
          tex_pos <= mp[47:0];
          state <= S_SHADE;
        end
        S_SHADE: state <= S_SHADEW;
        S_SHADEW: if (div_done) begin
          shade   <= dquot[16:0];
          cur_row <= {1'b0, req.top_row};
          end_row <= de_clamp;
          cur_col <= req.column;
          active  <= ({1'b0, req.top_row} < de_clamp)
                  && ({1'b0, req.column} < 11'(SCREEN_WIDTH));
          state   <= S_IDLE;
        end
        S_RD: begin
          chan <= 2'd0;
          state <= S_MUL;
        end
        // one channel through the multiplier per pass
        S_MUL: state <= S_COL;
        S_COL: begin
          color_acc[8*chan +: 8] <= mp[23:16];
          if (chan == 2'd2) state <= S_OUT;
          else begin
            chan <= chan + 2'd1;
            state <= S_MUL;
          end
        end
        S_OUT: if (emit) begin
          out_valid <= 1'b1;
          out_item.pixel_column <= cur_col;
          out_item.pixel_row    <= cur_row[8:0];
          out_item.pixel_color  <= color_acc;
          out_item.last         <= (cur_row + 10'd1) >= end_row;
          if ((cur_row + 10'd1) >= end_row) active <= 1'b0;
          cur_row <= cur_row + 10'd1;
          tex_pos <= tex_pos + {24'd0, row_step};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("request taken while busy");
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_item)) else $error("stalled result changed");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_busy) else $error("divider did not start");

endmodule
